// ===== design/voice_slot_allocator_assert.svh =====
// assertion macros for the voice slot allocator
`ifndef VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`define VOICE_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// plain property, checked on every clock out of reset
`define VSA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// next-cycle implication, checked out of reset
`define VSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define VSA_ASSERT(lbl, prop, msg)
`define VSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/vsa_pkg.sv =====
package vsa_pkg;

   // operation codes carried in the mode field
   localparam logic [2:0] MODE_ALLOC      = 3'd0;
   localparam logic [2:0] MODE_STOP_GROUP = 3'd1;
   localparam logic [2:0] MODE_STOP_ALL   = 3'd2;
   localparam logic [2:0] MODE_QUERY      = 3'd3;
   localparam logic [2:0] MODE_RELEASE    = 3'd4;

   // packed channel widths
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 48;

   localparam logic [31:0] ORDER_MAX = 32'hFFFF_FFFF;
   localparam logic [3:0]  SLOT_NONE = 4'hF;

   // one slot table entry as held in memory
   typedef struct packed {
      logic signed [15:0] grp;
      logic [31:0]        order;
   } entry_type;

endpackage

// ===== design/voice_slot_allocator.sv =====
// channel | dir | fields (lowest bit first)
// req     | in  | mode[2:0] group[18:3] exclude_slot[22:19] fade_us[54:23]
// rsp     | out | slot[3:0] stolen[4] hit[5] active_count[9:6] active_peak[13:10] steal_count[45:14]
//
// each item goes through accept, a scan of the slot table memory at one
// entry per cycle through a registered memory read, and a finish state
// that writes the allocated entry and loads the result.
// reset is synchronous; the table needs no clearing pass, inactive slots
// are never consulted. a new item is taken while a result waits; the
// finish state holds until the result register is free.
`include "voice_slot_allocator_assert.svh"

module voice_slot_allocator
   import vsa_pkg::*;
#(
   parameter int VOICES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mode, group, exclude_slot, fade_us, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // slot, stolen, hit, active_count, active_peak, steal_count, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW = $clog2(VOICES + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type          state_ff;
   logic [CW-1:0]      scan_ff;
   logic [2:0]         mode_ff;
   logic signed [15:0] grp_ff;
   logic [3:0]         ex_ff;
   logic               fade_zero_ff;
   logic [VOICES-1:0]  active_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      peak_ff;
   logic [31:0]        steal_ff;
   logic [31:0]        next_order_ff;
   logic               hit_ff;
   logic               free_found_ff;
   logic [IW-1:0]      free_idx_ff;
   logic               same_found_ff;
   logic [IW-1:0]      same_idx_ff;
   logic [31:0]        same_ord_ff;
   logic               any_found_ff;
   logic [IW-1:0]      any_idx_ff;
   logic [31:0]        any_ord_ff;

   logic               rsp_tvalid_ff;
   logic [3:0]         rsp_slot_ff;
   logic               rsp_stolen_ff;
   logic               rsp_hit_ff;
   logic [3:0]         rsp_cnt_ff;
   logic [3:0]         rsp_peak_ff;
   logic [31:0]        rsp_steal_ff;

   // slot table memory
   entry_type          mem [VOICES];
   entry_type          rd_data_ff;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   entry_type          mem_wdata;

   // scan-side decode of the entry returned last cycle
   logic               p_valid;
   logic [IW-1:0]      p_idx;
   logic               p_act;
   logic               grp_match;
   logic               ex_match;
   logic               stop_this;

   // finish-side selection
   logic               out_free;
   logic               fin_go;
   logic [IW-1:0]      fin_idx;
   logic               fin_stolen;
   logic [CW-1:0]      cnt_after;
   logic [CW-1:0]      peak_after;
   logic [31:0]        order_inc;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_steal_ff, rsp_peak_ff, rsp_cnt_ff,
                        rsp_hit_ff, rsp_stolen_ff, rsp_slot_ff};

   // read one entry per scan cycle while entries remain
   assign rd_en   = (state_ff == ST_SCAN) && (scan_ff < CW'(VOICES));
   assign rd_addr = scan_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-entry match logic
   always_comb begin
      p_valid   = (state_ff == ST_SCAN) && (scan_ff != '0);
      p_idx     = IW'(scan_ff - CW'(1));
      p_act     = active_ff[p_idx];
      grp_match = p_act && !grp_ff[15] && (rd_data_ff.grp == grp_ff);
      ex_match  = !ex_ff[3] && (int'(p_idx) == int'(ex_ff[2:0]));
      unique case (mode_ff)
         MODE_STOP_GROUP: stop_this = grp_match && !ex_match;
         MODE_STOP_ALL:   stop_this = p_act;
         MODE_RELEASE:    stop_this = p_act && ex_match;
         default:         stop_this = 1'b0;
      endcase
   end

   // slot choice and counters for the finish cycle
   always_comb begin
      out_free = !rsp_tvalid_ff || rsp_tready;
      fin_go   = (state_ff == ST_FINISH) && out_free;
      priority if (free_found_ff) begin
         fin_idx    = free_idx_ff;
         fin_stolen = 1'b0;
      end else if (same_found_ff) begin
         fin_idx    = same_idx_ff;
         fin_stolen = 1'b1;
      end else if (any_found_ff) begin
         fin_idx    = any_idx_ff;
         fin_stolen = 1'b1;
      end else begin
         fin_idx    = '0;
         fin_stolen = 1'b1;
      end
      if (mode_ff != MODE_ALLOC) begin
         fin_stolen = 1'b0;
      end
      cnt_after  = cnt_ff + CW'((mode_ff == MODE_ALLOC) && free_found_ff);
      peak_after = (cnt_after > peak_ff) ? cnt_after : peak_ff;
      order_inc  = next_order_ff + 32'd1;
      mem_we     = fin_go && (mode_ff == MODE_ALLOC);
      mem_waddr  = fin_idx;
      mem_wdata  = '{grp: grp_ff, order: next_order_ff};
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         cnt_ff        <= '0;
         peak_ff       <= '0;
         steal_ff      <= '0;
         next_order_ff <= 32'd1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !fin_go) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  mode_ff       <= req_tdata[2:0];
                  grp_ff        <= req_tdata[18:3];
                  ex_ff         <= req_tdata[22:19];
                  fade_zero_ff  <= (req_tdata[54:23] == 32'd0);
                  scan_ff       <= '0;
                  hit_ff        <= 1'b0;
                  free_found_ff <= 1'b0;
                  same_found_ff <= 1'b0;
                  any_found_ff  <= 1'b0;
                  same_ord_ff   <= ORDER_MAX;
                  any_ord_ff    <= ORDER_MAX;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + CW'(1);
               if (scan_ff == CW'(VOICES)) begin
                  state_ff <= ST_FINISH;
               end
               if (p_valid) begin
                  // stop, release and query
                  if (stop_this || (mode_ff == MODE_QUERY && grp_match)) begin
                     hit_ff <= 1'b1;
                  end
                  if (stop_this && fade_zero_ff) begin
                     active_ff[p_idx] <= 1'b0;
                     cnt_ff           <= cnt_ff - CW'(1);
                  end
                  // allocation search: first free, then oldest by group and overall
                  if (mode_ff == MODE_ALLOC) begin
                     if (!p_act && !free_found_ff) begin
                        free_found_ff <= 1'b1;
                        free_idx_ff   <= p_idx;
                     end
                     if (grp_match && rd_data_ff.order < same_ord_ff) begin
                        same_found_ff <= 1'b1;
                        same_idx_ff   <= p_idx;
                        same_ord_ff   <= rd_data_ff.order;
                     end
                     if (p_act && rd_data_ff.order < any_ord_ff) begin
                        any_found_ff <= 1'b1;
                        any_idx_ff   <= p_idx;
                        any_ord_ff   <= rd_data_ff.order;
                     end
                  end
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  if (mode_ff == MODE_ALLOC) begin
                     active_ff[fin_idx] <= 1'b1;
                     next_order_ff      <= (order_inc == 32'd0) ? 32'd1 : order_inc;
                     rsp_slot_ff        <= 4'(fin_idx);
                  end else begin
                     rsp_slot_ff <= SLOT_NONE;
                  end
                  cnt_ff        <= cnt_after;
                  peak_ff       <= peak_after;
                  steal_ff      <= steal_ff + 32'(fin_stolen);
                  rsp_stolen_ff <= fin_stolen;
                  rsp_hit_ff    <= hit_ff;
                  rsp_cnt_ff    <= 4'(cnt_after);
                  rsp_peak_ff   <= 4'(peak_after);
                  rsp_steal_ff  <= steal_ff + 32'(fin_stolen);
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `VSA_ASSERT(a_count_matches_flags, $countones(active_ff) == int'(cnt_ff), "active count out of step with slot flags")
   `VSA_ASSERT(a_peak_covers_count, (state_ff != ST_IDLE) || (peak_ff >= cnt_ff), "peak below active count")
   `VSA_ASSERT_NEXT(a_accept_starts_scan, req_tvalid && req_tready, (state_ff == ST_SCAN) && (scan_ff == '0), "accepted item did not start a scan")
   `VSA_ASSERT_NEXT(a_finish_waits, (state_ff == ST_FINISH) && rsp_tvalid && !rsp_tready, state_ff == ST_FINISH, "finish overwrote a pending result")

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import vsa_pkg::*;

   localparam int VOICES       = 8;
   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 500;
   localparam int NO_SLOT      = -1;
   localparam int NO_GROUP     = -1;
   localparam int MAX_PRINTS   = 40;

   // mode codes the block treats as no-ops
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   // req item as packed on req_tdata, last declared field in the lowest bits
   typedef struct packed {
      logic               pad;
      logic [31:0]        fade_us;
      logic signed [3:0]  exclude_slot;
      logic signed [15:0] grp;
      logic [2:0]         mode;
   } voice_req_type;

   // rsp item as packed on rsp_tdata, last declared field in the lowest bits
   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] steal_count;
      logic [3:0]  active_peak;
      logic [3:0]  active_count;
      logic        hit;
      logic        stolen;
      logic [3:0]  slot;
   } voice_rsp_type;

   // voice table predictor plus the queue of responses it still owes
   class voice_table_scoreboard;
      bit            active [VOICES];
      bit            stopping [VOICES];
      entry_type     entry [VOICES];
      logic [31:0]   next_stamp;
      logic [31:0]   steal_total;
      int            peak;
      voice_rsp_type due_rsp [$];
      int            errors;
      int            checked;

      function new();
         for (int i = 0; i < VOICES; i++) free_voice(i);
         next_stamp  = 32'd1;
         steal_total = '0;
         peak        = 0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void free_voice(int i);
         active[i]      = 1'b0;
         stopping[i]    = 1'b0;
         entry[i].grp   = 16'(NO_GROUP);
         entry[i].order = '0;
      endfunction

      // returns 1 when the voice was active and got touched
      function bit stop_voice(int i, logic [31:0] fade);
         if (!active[i]) return 1'b0;
         if (fade == '0) free_voice(i);
         else stopping[i] = 1'b1;
         return 1'b1;
      endfunction

      function voice_rsp_type predict_response(voice_req_type rq);
         voice_rsp_type rs;
         int            pick, same, any, cnt, ex, g;
         logic [31:0]   same_o, any_o;
         rs      = '0;
         rs.slot = SLOT_NONE;
         ex      = rq.exclude_slot;
         g       = rq.grp;
         cnt     = 0;
         case (rq.mode)
            MODE_ALLOC: begin
               // lowest free slot first, else steal the oldest voice of the group, else the oldest overall
               pick = NO_SLOT;
               for (int i = VOICES - 1; i >= 0; i--)
                  if (!active[i]) pick = i;
               if (pick < 0) begin
                  same   = NO_SLOT;
                  any    = NO_SLOT;
                  same_o = ORDER_MAX;
                  any_o  = ORDER_MAX;
                  for (int i = 0; i < VOICES; i++) begin
                     if (g >= 0 && entry[i].grp == rq.grp && entry[i].order < same_o) begin
                        same_o = entry[i].order;
                        same   = i;
                     end
                     if (entry[i].order < any_o) begin
                        any_o = entry[i].order;
                        any   = i;
                     end
                  end
                  if (same < 0) same = any;
                  if (same < 0) same = 0;
                  pick      = same;
                  rs.stolen = 1'b1;
                  steal_total++;
               end
               active[pick]      = 1'b1;
               stopping[pick]    = 1'b0;
               entry[pick].grp   = rq.grp;
               entry[pick].order = next_stamp;
               next_stamp++;
               if (next_stamp == '0) next_stamp = 32'd1;
               rs.slot = 4'(pick);
            end
            MODE_STOP_GROUP: begin
               if (g >= 0)
                  for (int i = 0; i < VOICES; i++)
                     if (i != ex && active[i] && entry[i].grp == rq.grp)
                        if (stop_voice(i, rq.fade_us)) rs.hit = 1'b1;
            end
            MODE_STOP_ALL: begin
               for (int i = 0; i < VOICES; i++)
                  if (stop_voice(i, rq.fade_us)) rs.hit = 1'b1;
            end
            MODE_QUERY: begin
               if (g >= 0)
                  for (int i = 0; i < VOICES; i++)
                     if (active[i] && entry[i].grp == rq.grp) rs.hit = 1'b1;
            end
            MODE_RELEASE: begin
               if (ex >= 0 && ex < VOICES) rs.hit = stop_voice(ex, rq.fade_us);
            end
            default: ;
         endcase
         for (int i = 0; i < VOICES; i++)
            if (active[i]) cnt++;
         if (cnt > peak) peak = cnt;
         rs.active_count = 4'(cnt);
         rs.active_peak  = 4'(peak);
         rs.steal_count  = steal_total;
         return rs;
      endfunction

      function void note_request(voice_req_type rq);
         due_rsp.push_back(predict_response(rq));
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTS) $display("mismatch at response %0d: %s", checked, msg);
         errors++;
      endtask

      task check_response(voice_rsp_type got);
         voice_rsp_type want;
         if (due_rsp.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = due_rsp.pop_front();
            if (got.slot !== want.slot)
               report($sformatf("slot %0h, want %0h", got.slot, want.slot));
            if (got.stolen !== want.stolen)
               report($sformatf("stolen %0b, want %0b", got.stolen, want.stolen));
            if (got.hit !== want.hit)
               report($sformatf("hit %0b, want %0b", got.hit, want.hit));
            if (got.active_count !== want.active_count)
               report($sformatf("active_count %0d, want %0d", got.active_count,
                                want.active_count));
            if (got.active_peak !== want.active_peak)
               report($sformatf("active_peak %0d, want %0d", got.active_peak,
                                want.active_peak));
            if (got.steal_count !== want.steal_count)
               report($sformatf("steal_count %0d, want %0d", got.steal_count,
                                want.steal_count));
         end
         checked++;
      endtask

      function int waiting();
         return due_rsp.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   voice_table_scoreboard sb = new();
   bit          steady      = 1'b0;
   bit          held_off    = 1'b0;
   int unsigned cycle_count = 0;

   voice_slot_allocator #(.VOICES(VOICES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one item, return at the edge that accepts it
   task automatic send_request(voice_req_type rq);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= rq;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic issue(logic [2:0] mode, int grp, int ex, logic [31:0] fade);
      voice_req_type rq;
      rq              = '0;
      rq.mode         = mode;
      rq.grp          = 16'(grp);
      rq.exclude_slot = 4'(ex);
      rq.fade_us      = fade;
      send_request(rq);
   endtask

   // biased toward allocation and a few group ids so the table fills and steals
   function automatic voice_req_type random_request();
      voice_req_type rq;
      int            r;
      rq = '0;
      r  = $urandom_range(0, 99);
      if (r < 42)      rq.mode = MODE_ALLOC;
      else if (r < 55) rq.mode = MODE_RELEASE;
      else if (r < 68) rq.mode = MODE_STOP_GROUP;
      else if (r < 73) rq.mode = MODE_STOP_ALL;
      else if (r < 94) rq.mode = MODE_QUERY;
      else             rq.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      r = $urandom_range(0, 99);
      if (r < 70)      rq.grp = 16'($urandom_range(0, 3));
      else if (r < 80) rq.grp = 16'(NO_GROUP);
      else if (r < 95) rq.grp = 16'($urandom);
      else             rq.grp = 16'h7FFF;
      if ($urandom_range(0, 3) != 0) rq.exclude_slot = 4'($urandom_range(0, VOICES - 1));
      else                           rq.exclude_slot = 4'($urandom);
      r = $urandom_range(0, 9);
      if (r < 5)       rq.fade_us = '0;
      else if (r < 9)  rq.fade_us = $urandom;
      else             rq.fade_us = ORDER_MAX;
      return rq;
   endfunction

   // item monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(voice_rsp_type'(rsp_tdata));
         if (req_tvalid && req_tready) sb.note_request(voice_req_type'(req_tdata));
      end
   end

   // result side: random stalls, one long hold-off so the block backs up
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         if (!held_off && sb.checked >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the table, then steal by group, without group and with no match
      issue(MODE_QUERY, 5, NO_SLOT, '0);
      issue(MODE_RELEASE, 0, 0, '0);
      issue(MODE_ALLOC, 5, NO_SLOT, '0);
      issue(MODE_ALLOC, 5, NO_SLOT, '0);
      issue(MODE_ALLOC, NO_GROUP, NO_SLOT, '0);
      issue(MODE_ALLOC, 32767, NO_SLOT, '0);
      issue(MODE_ALLOC, -32768, NO_SLOT, '0);
      issue(MODE_ALLOC, 7, NO_SLOT, '0);
      issue(MODE_ALLOC, 7, NO_SLOT, '0);
      issue(MODE_ALLOC, 5, NO_SLOT, '0);
      issue(MODE_ALLOC, 5, NO_SLOT, '0);
      issue(MODE_ALLOC, NO_GROUP, NO_SLOT, '0);
      issue(MODE_ALLOC, 9, NO_SLOT, '0);
      issue(MODE_QUERY, 7, NO_SLOT, '0);
      issue(MODE_QUERY, NO_GROUP, NO_SLOT, '0);
      // fades, exclusions and stops of voices already stopping
      issue(MODE_STOP_GROUP, 5, 1, 32'd100);
      issue(MODE_STOP_GROUP, 5, NO_SLOT, 32'd100);
      issue(MODE_STOP_GROUP, 7, -8, '0);
      issue(MODE_STOP_GROUP, -5, NO_SLOT, '0);
      // release out of range and with the longest fade
      issue(MODE_RELEASE, 0, NO_SLOT, '0);
      issue(MODE_RELEASE, 0, -8, '0);
      issue(MODE_RELEASE, 0, 3, ORDER_MAX);
      issue(MODE_SPARE_FIRST, 32767, 7, ORDER_MAX);
      issue(MODE_SPARE_LAST, -1, -1, ORDER_MAX);
      issue(MODE_STOP_ALL, 0, NO_SLOT, 32'd1);
      issue(MODE_STOP_ALL, 0, NO_SLOT, '0);
      issue(MODE_STOP_ALL, 0, NO_SLOT, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 1200 && n < 1400);
         send_request(random_request());
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      // drain, then watch for stray responses
      @(posedge clock);
      while (sb.waiting() != 0) @(posedge clock);
      repeat (4 * (VOICES + 3)) @(posedge clock);

      if (sb.errors == 0 && sb.waiting() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/vsa_pkg.sv
design/voice_slot_allocator.sv
test/tb_top.sv
